/* rtl/core/fud_pkg.sv */
package fud_pkg;

    // character codes used by the decoder
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LF    = 8'h66;

    localparam int unsigned BYTE_W = 8;

    // decoder phase
    typedef enum logic [1:0] {
        PH_PLAIN     = 2'd0,
        PH_AFTER_PCT = 2'd1,
        PH_AFTER_ONE = 2'd2,
        PH_VERBATIM  = 2'd3
    } phase_t;

    // one input item
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
    } fud_item_t;

    // one decode result headed for the output register
    typedef struct packed {
        logic              has;
        logic [BYTE_W-1:0] data;
        logic              flag;
        logic              last;
    } fud_res_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_0) && (c <= CH_9);
    endfunction

    function automatic logic hex_ok(input logic [7:0] c);
        return is_digit(c) || ((c >= CH_UA) && (c <= CH_UF)) || ((c >= CH_LA) && (c <= CH_LF));
    endfunction

    // nibble value of a hex digit, valid only when hex_ok is true
    function automatic logic [3:0] hex_nib(input logic [7:0] c);
        return is_digit(c) ? c[3:0] : (c[3:0] + 4'd9);
    endfunction

    function automatic logic is_ws(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_PLUS) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    function automatic logic [7:0] plain_map(input logic [7:0] c);
        return (c == CH_PLUS) ? CH_SPACE : c;
    endfunction

    // value of an escape, parsed like a base-16 strtol
    function automatic logic [7:0] escape_value(input logic [7:0] c1, input logic have2,
                                                input logic [7:0] c2);
        logic       h1_ok;
        logic       h2_ok;
        logic [3:0] n1;
        logic [3:0] n2;
        logic [7:0] v;
        h1_ok = hex_ok(c1);
        h2_ok = have2 && hex_ok(c2);
        n1    = hex_nib(c1);
        n2    = hex_nib(c2);
        v     = 8'd0;
        if (h1_ok)
        begin
            v = h2_ok ? {n1, n2} : {4'd0, n1};
        end
        else if (h2_ok)
        begin
            if (is_ws(c1))
            begin
                v = {4'd0, n2};
            end
            else if (c1 == CH_MINUS)
            begin
                v = 8'd0 - {4'd0, n2};
            end
        end
        return v;
    endfunction

endpackage

/* rtl/core/form_url_decoder_unit.sv */
// form-post string decoder
// input stream: one encoded byte per item on s_tdata, s_tlast marks the final
// byte of a string. '+' becomes a space, '%' followed by up to two bytes is
// replaced by their hex value; a zero value emits nothing and the byte after
// it is decoded as plain text, without starting an escape.
// output stream: m_tdata holds the decoded byte, m_tuser is set when it is a
// real character, m_tlast marks the end of the string. every last input byte
// gives exactly one output item (m_tuser low and data zero if nothing was
// decoded), other input bytes give zero or one item.
// path: an accepted item waits in the input register, then its result moves
// to the result register, from which it is offered on the output.
// throughput: one item per cycle while the output is not stalled; the only
// loop is the 2-bit phase and the stored first escape byte.
// reset: all valids clear and the decoder returns to plain text.
// stall: while m_tready is low the result register holds its item; the input
// register still takes one more item, then s_tready drops until the output
// drains.
module form_url_decoder_unit (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    input  logic       s_tlast,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic       m_tuser,   // [0] out_valid
    output logic       m_tlast
);

    fud_pkg::fud_item_t in_item;
    fud_pkg::fud_item_t item;
    fud_pkg::fud_res_t  res;
    fud_pkg::fud_res_t  out_res;
    fud_pkg::phase_t    phase;
    logic               item_vld;
    logic               out_free;
    logic               fire;

    assign in_item.data = s_tdata;
    assign in_item.last = s_tlast;

    // an item moves through decode when the result register can take it
    assign fire = item_vld && out_free;

    fud_in_stage u_in (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_item  (in_item),
        .take     (fire),
        .vld      (item_vld),
        .item     (item)
    );

    fud_decode u_dec (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .item  (item),
        .res   (res),
        .phase (phase)
    );

    fud_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .res       (res),
        .free      (out_free),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

    assign m_tdata = out_res.data;
    assign m_tuser = out_res.flag;
    assign m_tlast = out_res.last;

    // an item without a character only ever closes a string
    a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |-> m_tlast)
        else $error("empty output item without tlast");

    // an empty item carries zero data
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |-> (m_tdata == 8'd0))
        else $error("empty output item with nonzero data");

    // end of string puts the decoder back to plain text
    a_last_resets: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && item.last) |=> (phase == fud_pkg::PH_PLAIN))
        else $error("decoder not in plain text after last byte");

    // input only stalls when the input register holds an item
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (item_vld && m_tvalid && !m_tready))
        else $error("input stalled without cause");

endmodule

/* rtl/core/fud_in_stage.sv */
module fud_in_stage (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  fud_pkg::fud_item_t   in_item,
    input  logic                 take,
    output logic                 vld,
    output fud_pkg::fud_item_t   item
);

    logic               vld_reg;
    logic               vld_next;
    fud_pkg::fud_item_t item_reg;
    logic               load;

    // stage is free when empty or being drained this cycle
    assign in_ready = !vld_reg || take;
    assign load     = in_valid && in_ready;

    always_comb
    begin
        vld_next = vld_reg;
        if (load)
        begin
            vld_next = 1'b1;
        end
        else if (take)
        begin
            vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // payload capture
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= in_item;
        end
    end

    assign vld  = vld_reg;
    assign item = item_reg;

endmodule

/* rtl/core/fud_decode.sv */
module fud_decode (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               fire,
    input  fud_pkg::fud_item_t item,
    output fud_pkg::fud_res_t  res,
    output fud_pkg::phase_t    phase
);

    fud_pkg::phase_t phase_reg;
    fud_pkg::phase_t phase_next;
    logic [7:0]      first_reg;
    logic [7:0]      first_next;
    logic            emit;
    logic [7:0]      val;

    // next phase and decoded value
    always_comb
    begin
        emit       = 1'b0;
        val        = 8'd0;
        phase_next = fud_pkg::PH_PLAIN;
        first_next = first_reg;
        case (phase_reg)
            fud_pkg::PH_PLAIN:
            begin
                if (item.data == fud_pkg::CH_PCT)
                begin
                    phase_next = fud_pkg::PH_AFTER_PCT;
                end
                else
                begin
                    emit = 1'b1;
                    val  = fud_pkg::plain_map(item.data);
                end
            end
            fud_pkg::PH_AFTER_PCT:
            begin
                first_next = item.data;
                phase_next = fud_pkg::PH_AFTER_ONE;
                if (item.last)
                begin
                    val  = fud_pkg::escape_value(item.data, 1'b0, 8'd0);
                    emit = (val != 8'd0);
                end
            end
            fud_pkg::PH_AFTER_ONE:
            begin
                val        = fud_pkg::escape_value(first_reg, 1'b1, item.data);
                emit       = (val != 8'd0);
                phase_next = emit ? fud_pkg::PH_PLAIN : fud_pkg::PH_VERBATIM;
            end
            fud_pkg::PH_VERBATIM:
            begin
                emit       = 1'b1;
                val        = fud_pkg::plain_map(item.data);
                phase_next = fud_pkg::PH_PLAIN;
            end
            default:
            begin
                phase_next = fud_pkg::PH_PLAIN;
            end
        endcase
        // end of string returns to the reset state
        if (item.last)
        begin
            phase_next = fud_pkg::PH_PLAIN;
            first_next = 8'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= fud_pkg::PH_PLAIN;
            first_reg <= 8'd0;
        end
        else if (fire)
        begin
            phase_reg <= phase_next;
            first_reg <= first_next;
        end
    end

    // result: one for each byte that emits a character or is a last byte
    assign res.has  = emit || item.last;
    assign res.data = emit ? val : 8'd0;
    assign res.flag = emit;
    assign res.last = item.last;
    assign phase    = phase_reg;

endmodule

/* rtl/core/fud_out_stage.sv */
module fud_out_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  fud_pkg::fud_res_t res,
    output logic              free,
    output logic              out_valid,
    input  logic              out_ready,
    output fud_pkg::fud_res_t out_res
);

    logic              vld_reg;
    logic              vld_next;
    fud_pkg::fud_res_t res_reg;

    // register can take a new result when empty or being read
    assign free = !vld_reg || out_ready;

    always_comb
    begin
        vld_next = vld_reg;
        if (fire)
        begin
            vld_next = res.has;
        end
        else if (out_ready)
        begin
            vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && res.has)
        begin
            res_reg <= res;
        end
    end

    assign out_valid = vld_reg;
    assign out_res   = res_reg;

endmodule
